FILE: hw/rtl/gmd_pkg.sv
`default_nettype none
package gmd_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELL_CNT = MAX_ROWS * MAX_COLS;
  localparam int DEPTH_W  = 9;
  localparam int DIM_W    = 5;
  localparam int DIR_W    = 3;
  localparam int UPC_W    = 4;
  localparam int STAT_W   = 3;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_WRITTEN = 3'd0,
    ST_FOUND   = 3'd1,
    ST_NOPATH  = 3'd2,
    ST_READ    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE_CELL,
    OP_READ_ISSUE,
    OP_SWEEP_READ,
    OP_SWEEP_CLEAR,
    OP_INIT,
    OP_PROBE,
    OP_PUSH,
    OP_SAVE_TOP,
    OP_POP,
    OP_LOAD_TOP
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IDX_OOR,
    C_SWEEP_DONE,
    C_START_GOAL,
    C_DIR_DONE,
    C_NB_BAD,
    C_NB_NOT_GOAL,
    C_LAST
  } cond_t;

  // microprogram addresses
  localparam logic [UPC_W-1:0] U_WR        = 4'd0;
  localparam logic [UPC_W-1:0] U_RD0       = 4'd1;
  localparam logic [UPC_W-1:0] U_RD1       = 4'd2;
  localparam logic [UPC_W-1:0] U_RANGE     = 4'd3;
  localparam logic [UPC_W-1:0] U_SWEEP     = 4'd4;
  localparam logic [UPC_W-1:0] U_SWEEP_CLR = 4'd5;
  localparam logic [UPC_W-1:0] U_INIT      = 4'd6;
  localparam logic [UPC_W-1:0] U_LOOP      = 4'd7;
  localparam logic [UPC_W-1:0] U_CHECK     = 4'd8;
  localparam logic [UPC_W-1:0] U_PUSH      = 4'd9;
  localparam logic [UPC_W-1:0] U_SUCC      = 4'd10;
  localparam logic [UPC_W-1:0] U_POP       = 4'd11;
  localparam logic [UPC_W-1:0] U_POPLD     = 4'd12;
  localparam logic [UPC_W-1:0] U_FAIL      = 4'd13;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             fin;
    status_t          status;
  } ucw_t;

  typedef struct packed {
    logic idx_oor;
    logic sweep_done;
    logic start_goal;
    logic dir_done;
    logic nb_bad;
    logic nb_not_goal;
    logic last;
  } dp_flags_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIR_W-1:0] dir;
  } stk_ent_t;

  function automatic ucw_t mk_ucw(input op_t op, input cond_t cond,
                                  input logic [UPC_W-1:0] target, input logic fin,
                                  input status_t status);
    ucw_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.fin    = fin;
    w.status = status;
    return w;
  endfunction

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucw_t w;
    case (upc)
      U_WR:        w = mk_ucw(OP_WRITE_CELL,  C_NEVER,       U_WR,    1'b1, ST_WRITTEN);
      U_RD0:       w = mk_ucw(OP_READ_ISSUE,  C_IDX_OOR,     U_RANGE, 1'b0, ST_WRITTEN);
      U_RD1:       w = mk_ucw(OP_NOP,         C_NEVER,       U_WR,    1'b1, ST_READ);
      U_RANGE:     w = mk_ucw(OP_NOP,         C_NEVER,       U_WR,    1'b1, ST_RANGE);
      U_SWEEP:     w = mk_ucw(OP_SWEEP_READ,  C_SWEEP_DONE,  U_INIT,  1'b0, ST_WRITTEN);
      U_SWEEP_CLR: w = mk_ucw(OP_SWEEP_CLEAR, C_ALWAYS,      U_SWEEP, 1'b0, ST_WRITTEN);
      U_INIT:      w = mk_ucw(OP_INIT,        C_START_GOAL,  U_SUCC,  1'b0, ST_WRITTEN);
      U_LOOP:      w = mk_ucw(OP_PROBE,       C_DIR_DONE,    U_POP,   1'b0, ST_WRITTEN);
      U_CHECK:     w = mk_ucw(OP_NOP,         C_NB_BAD,      U_LOOP,  1'b0, ST_WRITTEN);
      U_PUSH:      w = mk_ucw(OP_PUSH,        C_NB_NOT_GOAL, U_LOOP,  1'b0, ST_WRITTEN);
      U_SUCC:      w = mk_ucw(OP_SAVE_TOP,    C_NEVER,       U_WR,    1'b1, ST_FOUND);
      U_POP:       w = mk_ucw(OP_POP,         C_LAST,        U_FAIL,  1'b0, ST_WRITTEN);
      U_POPLD:     w = mk_ucw(OP_LOAD_TOP,    C_ALWAYS,      U_LOOP,  1'b0, ST_WRITTEN);
      U_FAIL:      w = mk_ucw(OP_NOP,         C_NEVER,       U_WR,    1'b1, ST_NOPATH);
      default:     w = mk_ucw(OP_NOP,         C_NEVER,       U_WR,    1'b1, ST_RANGE);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry_point(input action_t a);
    logic [UPC_W-1:0] u;
    case (a)
      ACT_WRITE:  u = U_WR;
      ACT_SEARCH: u = U_SWEEP;
      ACT_READ:   u = U_RD0;
      default:    u = U_RANGE;
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gmd_ram.sv
`default_nettype none
module gmd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gmd_useq.sv
`default_nettype none
module gmd_useq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire gmd_pkg::action_t   action,
  input  wire gmd_pkg::dp_flags_t flags,
  input  wire logic               out_free,
  output gmd_pkg::ucw_t           ucw,
  output logic                    busy,
  output logic                    fire
);
  import gmd_pkg::*;

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  ucw_t             rom_w;
  logic             jump;

  assign rom_w = ucode_rom(upc_r);
  assign busy  = busy_r;
  assign fire  = busy_r & rom_w.fin & out_free;

  always_comb begin
    ucw = rom_w;
    if (!busy_r) begin
      ucw.op  = OP_NOP;
      ucw.fin = 1'b0;
    end
  end

  always_comb begin
    case (rom_w.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_IDX_OOR:     jump = flags.idx_oor;
      C_SWEEP_DONE:  jump = flags.sweep_done;
      C_START_GOAL:  jump = flags.start_goal;
      C_DIR_DONE:    jump = flags.dir_done;
      C_NB_BAD:      jump = flags.nb_bad;
      C_NB_NOT_GOAL: jump = flags.nb_not_goal;
      C_LAST:        jump = flags.last;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry_point(action);
    end else if (busy_r) begin
      if (rom_w.fin) begin
        // hold on the last step until the output register frees up
        if (out_free) begin
          busy_nxt = 1'b0;
        end
      end else begin
        upc_nxt = jump ? rom_w.target : upc_r + UPC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= U_WR;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gmd_dpath.sv
`default_nettype none
module gmd_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire logic [gmd_pkg::ROW_W-1:0]  item_row,
  input  wire logic [gmd_pkg::COL_W-1:0]  item_col,
  input  wire logic                       item_blocked,
  input  wire logic [gmd_pkg::ADDR_W-1:0] item_index,
  input  wire logic [gmd_pkg::DIM_W-1:0]  rows_eff,
  input  wire logic [gmd_pkg::DIM_W-1:0]  cols_eff,
  input  wire gmd_pkg::op_t               op,
  output gmd_pkg::dp_flags_t              flags,
  output logic [gmd_pkg::DEPTH_W-1:0]     depth,
  output gmd_pkg::stk_ent_t               rd_ent,
  output logic                            clr_busy
);
  import gmd_pkg::*;

  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;
  localparam int STK_W = $bits(stk_ent_t);

  // latched item
  logic [ROW_W-1:0]   item_row_r;
  logic [COL_W-1:0]   item_col_r;
  logic               item_blk_r;
  logic [ADDR_W-1:0]  item_idx_r;

  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] sweep_idx_r, sweep_idx_nxt;
  stk_ent_t           cur_r, cur_nxt;
  logic [ROW_W-1:0]   nr_r, nr_nxt;
  logic [COL_W-1:0]   nc_r, nc_nxt;
  logic               nb_ok_r, nb_ok_nxt;
  logic               clr_busy_r;
  logic [ADDR_W-1:0]  clr_cnt_r;

  logic [ROW_W-1:0]   nb_row;
  logic [COL_W-1:0]   nb_col;
  logic               nb_ok;

  logic [DEPTH_W-1:0] depth_m1, depth_m2;
  logic [DIM_W-1:0]   rows_m1, cols_m1;
  logic [ROW_W-1:0]   goal_row;
  logic [COL_W-1:0]   goal_col;

  logic               blk_we, blk_re, blk_wd, blk_rd;
  logic [ADDR_W-1:0]  blk_addr;
  logic               vis_we, vis_re, vis_wd, vis_rd;
  logic [ADDR_W-1:0]  vis_addr;
  logic               stk_we, stk_re;
  logic [ADDR_W-1:0]  stk_addr;
  stk_ent_t           stk_wd, stk_rd;
  logic [STK_W-1:0]   stk_rdata;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign depth_m2 = depth_r - DEPTH_W'(2);
  assign rows_m1  = rows_eff - DIM_W'(1);
  assign cols_m1  = cols_eff - DIM_W'(1);
  assign goal_row = rows_m1[ROW_W-1:0];
  assign goal_col = cols_m1[COL_W-1:0];
  assign stk_rd   = stk_rdata;

  assign depth    = depth_r;
  assign rd_ent   = stk_rd;
  assign clr_busy = clr_busy_r;

  assign flags.idx_oor     = {1'b0, item_idx_r} >= depth_r;
  assign flags.sweep_done  = sweep_idx_r == depth_r;
  assign flags.start_goal  = (rows_eff == DIM_W'(1)) && (cols_eff == DIM_W'(1));
  assign flags.dir_done    = cur_r.dir == DIR_DONE;
  assign flags.nb_bad      = !nb_ok_r || blk_rd || vis_rd;
  assign flags.nb_not_goal = !((nr_r == goal_row) && (nc_r == goal_col));
  assign flags.last        = depth_r == DEPTH_W'(1);

  // neighbor of the stack top in the current direction
  always_comb begin
    nb_row = cur_r.row;
    nb_col = cur_r.col;
    nb_ok  = 1'b0;
    case (cur_r.dir)
      DIR_RIGHT: begin
        nb_col = cur_r.col + COL_W'(1);
        nb_ok  = ({1'b0, cur_r.col} + DIM_W'(1)) < cols_eff;
      end
      DIR_DOWN: begin
        nb_row = cur_r.row + ROW_W'(1);
        nb_ok  = ({1'b0, cur_r.row} + DIM_W'(1)) < rows_eff;
      end
      DIR_LEFT: begin
        nb_col = cur_r.col - COL_W'(1);
        nb_ok  = cur_r.col != '0;
      end
      DIR_UP: begin
        nb_row = cur_r.row - ROW_W'(1);
        nb_ok  = cur_r.row != '0;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    depth_nxt     = depth_r;
    sweep_idx_nxt = sweep_idx_r;
    cur_nxt       = cur_r;
    nr_nxt        = nr_r;
    nc_nxt        = nc_r;
    nb_ok_nxt     = nb_ok_r;
    blk_we   = 1'b0;
    blk_re   = 1'b0;
    blk_wd   = 1'b0;
    blk_addr = '0;
    vis_we   = 1'b0;
    vis_re   = 1'b0;
    vis_wd   = 1'b0;
    vis_addr = '0;
    stk_we   = 1'b0;
    stk_re   = 1'b0;
    stk_addr = '0;
    stk_wd   = cur_r;
    if (in_fire) begin
      sweep_idx_nxt = '0;
    end
    case (op)
      OP_WRITE_CELL: begin
        blk_we   = 1'b1;
        blk_addr = {item_row_r, item_col_r};
        blk_wd   = item_blk_r;
      end
      OP_READ_ISSUE: begin
        stk_re   = 1'b1;
        stk_addr = item_idx_r;
      end
      OP_SWEEP_READ: begin
        stk_re   = 1'b1;
        stk_addr = sweep_idx_r[ADDR_W-1:0];
      end
      OP_SWEEP_CLEAR: begin
        // drop the visited marks left behind by the previous path
        vis_we        = 1'b1;
        vis_addr      = {stk_rd.row, stk_rd.col};
        vis_wd        = 1'b0;
        sweep_idx_nxt = sweep_idx_r + DEPTH_W'(1);
      end
      OP_INIT: begin
        depth_nxt = DEPTH_W'(1);
        cur_nxt   = '0;
        vis_we    = 1'b1;
        vis_addr  = '0;
        vis_wd    = 1'b1;
      end
      OP_PROBE: begin
        nr_nxt    = nb_row;
        nc_nxt    = nb_col;
        nb_ok_nxt = nb_ok;
        blk_re    = 1'b1;
        blk_addr  = {nb_row, nb_col};
        vis_re    = 1'b1;
        vis_addr  = {nb_row, nb_col};
        if (cur_r.dir != DIR_DONE) begin
          cur_nxt.dir = cur_r.dir + DIR_W'(1);
        end
      end
      OP_PUSH: begin
        // stack top lives in cur_r, entries below it in the ram
        stk_we      = 1'b1;
        stk_addr    = depth_m1[ADDR_W-1:0];
        stk_wd      = cur_r;
        cur_nxt.row = nr_r;
        cur_nxt.col = nc_r;
        cur_nxt.dir = DIR_RIGHT;
        depth_nxt   = depth_r + DEPTH_W'(1);
        vis_we      = 1'b1;
        vis_addr    = {nr_r, nc_r};
        vis_wd      = 1'b1;
      end
      OP_SAVE_TOP: begin
        stk_we   = 1'b1;
        stk_addr = depth_m1[ADDR_W-1:0];
        stk_wd   = cur_r;
      end
      OP_POP: begin
        vis_we    = 1'b1;
        vis_addr  = {cur_r.row, cur_r.col};
        vis_wd    = 1'b0;
        depth_nxt = depth_m1;
        stk_re    = 1'b1;
        stk_addr  = depth_m2[ADDR_W-1:0];
      end
      OP_LOAD_TOP: begin
        cur_nxt = stk_rd;
      end
      default: begin
      end
    endcase
    // power-up clearing pass over both cell maps
    if (clr_busy_r) begin
      blk_we   = 1'b1;
      blk_re   = 1'b0;
      blk_wd   = 1'b0;
      blk_addr = clr_cnt_r;
      vis_we   = 1'b1;
      vis_re   = 1'b0;
      vis_wd   = 1'b0;
      vis_addr = clr_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      depth_r <= depth_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == {ADDR_W{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_idx_r <= sweep_idx_nxt;
    cur_r       <= cur_nxt;
    nr_r        <= nr_nxt;
    nc_r        <= nc_nxt;
    nb_ok_r     <= nb_ok_nxt;
    if (in_fire) begin
      item_row_r <= item_row;
      item_col_r <= item_col;
      item_blk_r <= item_blocked;
      item_idx_r <= item_index;
    end
  end

  gmd_ram #(.WIDTH(1), .DEPTH(CELL_CNT)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .re    (blk_re),
    .addr  (blk_addr),
    .wdata (blk_wd),
    .rdata (blk_rd)
  );

  gmd_ram #(.WIDTH(1), .DEPTH(CELL_CNT)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .re    (vis_re),
    .addr  (vis_addr),
    .wdata (vis_wd),
    .rdata (vis_rd)
  );

  gmd_ram #(.WIDTH(STK_W), .DEPTH(CELL_CNT)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .re    (stk_re),
    .addr  (stk_addr),
    .wdata (stk_wd),
    .rdata (stk_rdata)
  );

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(CELL_CNT))
    else $error("stack depth beyond cell count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_POP) |-> (depth_r != '0))
    else $error("pop on empty stack");

  a_push_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PUSH) |-> (nb_ok_r && !blk_rd && !vis_rd && depth_r < DEPTH_W'(CELL_CNT)))
    else $error("push of a cell that is not open");

  a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_LOAD_TOP) |-> ($past(op) == OP_POP))
    else $error("stack top reload without a pop");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/grid_maze_dfs_path_search_core.sv
`default_nettype none
// Maze path search engine. Cells are written one transfer at a time into a
// 16x16 blocked map; a search transfer runs a backtracking depth-first walk
// from the top-left to the bottom-right cell of the grid in use (neighbors
// tried right, down, left, up) and a read transfer returns one cell of the
// found path by index. Every transfer yields exactly one result, carrying the
// current path length. The input is stalled while a transfer is in progress,
// so the next transfer is taken only once the result of the last one has
// been registered at the output. A search first clears the visited marks of
// the previous path, then probes neighbors, pushing each open cell and
// backtracking from dead ends; the microcode steps share one single-port ram
// for each of the blocked map, the visited map and the path stack. After
// reset the engine stalls its input while it clears both cell maps;
// grid size writes are taken at any time but should only be made while idle.
module grid_maze_dfs_path_search_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [gmd_pkg::DIM_W-1:0]    cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_action,
  input  wire logic [gmd_pkg::ROW_W-1:0]    in_cell_row,
  input  wire logic [gmd_pkg::COL_W-1:0]    in_cell_col,
  input  wire logic                         in_cell_blocked,
  input  wire logic [gmd_pkg::ADDR_W-1:0]   in_entry_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [gmd_pkg::STAT_W-1:0]        out_status,
  output logic [gmd_pkg::DEPTH_W-1:0]       out_path_length,
  output logic [gmd_pkg::ROW_W-1:0]         out_entry_row,
  output logic [gmd_pkg::COL_W-1:0]         out_entry_col
);
  import gmd_pkg::*;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  logic [DIM_W-1:0]   rows_r, cols_r;
  logic [DIM_W-1:0]   rows_eff, cols_eff;

  logic               in_fire, out_free, fire, busy, clr_busy;
  ucw_t               ucw;
  dp_flags_t          flags;
  logic [DEPTH_W-1:0] depth;
  stk_ent_t           rd_ent;

  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [DEPTH_W-1:0] out_len_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;

  // out-of-range sizes clamp to 1 and to the storage limit
  always_comb begin
    rows_eff = rows_r;
    if (rows_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (rows_r > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end
    cols_eff = cols_r;
    if (cols_r == '0) begin
      cols_eff = DIM_W'(1);
    end else if (cols_r > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_ROWS);
      cols_r <= DIM_W'(MAX_COLS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_r <= cfg_data;
        CFG_COLS: cols_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy | clr_busy;
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  gmd_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .action   (action_t'(in_action)),
    .flags    (flags),
    .out_free (out_free),
    .ucw      (ucw),
    .busy     (busy),
    .fire     (fire)
  );

  gmd_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .item_row     (in_cell_row),
    .item_col     (in_cell_col),
    .item_blocked (in_cell_blocked),
    .item_index   (in_entry_index),
    .rows_eff     (rows_eff),
    .cols_eff     (cols_eff),
    .op           (ucw.op),
    .flags        (flags),
    .depth        (depth),
    .rd_ent       (rd_ent),
    .clr_busy     (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= ucw.status;
      out_len_r    <= depth;
      if (ucw.status == ST_READ) begin
        out_row_r <= rd_ent.row;
        out_col_r <= rd_ent.col;
      end else begin
        out_row_r <= '0;
        out_col_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_path_length = out_len_r;
  assign out_entry_row   = out_row_r;
  assign out_entry_col   = out_col_r;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
  import gmd_pkg::*;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int DIR_RIGHT = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_DONE  = 4;

  localparam int ITEM_TARGET = 1400;
  localparam int IDLE_PAD    = 8;
  localparam int LONG_HOLD   = 150;
  localparam int QUIET_LIMIT = 50000;

  typedef struct packed {
    status_t              status;
    logic [DEPTH_W-1:0]   length;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
  } answer_t;

  class maze_path_tracker;
    bit       blocked [CELL_CNT];
    int       trail_row [CELL_CNT];
    int       trail_col [CELL_CNT];
    int       trail_dir [CELL_CNT];
    int       trail_len;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    answer_t  awaited [$];
    int       bad_count;

    function new();
      foreach (blocked[k]) blocked[k] = 1'b0;
      trail_len = 0;
      rows_reg  = 5'd16;
      cols_reg  = 5'd16;
      bad_count = 0;
    endfunction

    function void set_dims(logic [DIM_W-1:0] rv, logic [DIM_W-1:0] cv);
      rows_reg = rv;
      cols_reg = cv;
    endfunction

    // zero acts as one, anything past the storage acts as its size
    function int span(logic [DIM_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
    endfunction

    // backtracking walk, marks cleared on the way back out
    function bit walk_maze();
      bit seen [CELL_CNT];
      int nrows, ncols, goal_r, goal_c, t, d, nr, nc, k;
      bit hit;
      nrows  = span(rows_reg, MAX_ROWS);
      ncols  = span(cols_reg, MAX_COLS);
      goal_r = nrows - 1;
      goal_c = ncols - 1;
      for (k = 0; k < CELL_CNT; k++) seen[k] = 1'b0;
      trail_row[0] = 0;
      trail_col[0] = 0;
      trail_dir[0] = DIR_RIGHT;
      trail_len = 1;
      if (goal_r == 0 && goal_c == 0) return 1'b1;
      seen[0] = 1'b1;
      hit = 1'b0;
      while (trail_len > 0 && !hit) begin
        t = trail_len - 1;
        if (trail_dir[t] >= DIR_DONE) begin
          seen[trail_row[t] * MAX_COLS + trail_col[t]] = 1'b0;
          trail_len = t;
        end else begin
          d = trail_dir[t];
          trail_dir[t] = d + 1;
          nr = trail_row[t];
          nc = trail_col[t];
          case (d)
            DIR_RIGHT: nc = nc + 1;
            DIR_DOWN:  nr = nr + 1;
            DIR_LEFT:  nc = nc - 1;
            default:   nr = nr - 1;
          endcase
          if (nr >= 0 && nr < nrows && nc >= 0 && nc < ncols) begin
            k = nr * MAX_COLS + nc;
            if (!blocked[k] && !seen[k]) begin
              if (trail_len < CELL_CNT) begin
                trail_row[trail_len] = nr;
                trail_col[trail_len] = nc;
                trail_dir[trail_len] = DIR_RIGHT;
                trail_len++;
              end
              if (nr == goal_r && nc == goal_c) hit = 1'b1;
              else seen[k] = 1'b1;
            end
          end
        end
      end
      return hit;
    endfunction

    function void note_transfer(logic [1:0] act, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                logic b, logic [ADDR_W-1:0] idx);
      answer_t a;
      a.row = '0;
      a.col = '0;
      case (act)
        ACT_WRITE: begin
          blocked[r * MAX_COLS + c] = b;
          a.status = ST_WRITTEN;
        end
        ACT_SEARCH: a.status = walk_maze() ? ST_FOUND : ST_NOPATH;
        ACT_READ: begin
          if (idx < trail_len) begin
            a.row    = ROW_W'(trail_row[idx]);
            a.col    = COL_W'(trail_col[idx]);
            a.status = ST_READ;
          end else begin
            a.status = ST_RANGE;
          end
        end
        default: a.status = ST_RANGE;
      endcase
      a.length = DEPTH_W'(trail_len);
      awaited = {awaited, a};
    endfunction

    function void check_answer(logic [STAT_W-1:0] st, logic [DEPTH_W-1:0] len,
                               logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
      answer_t want;
      if (awaited.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: status %0d length %0d entry (%0d,%0d)", st, len, r, c);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || len !== want.length || r !== want.row || c !== want.col) begin
        bad_count++;
        if (bad_count <= 10)
          $display("expected status %0d length %0d entry (%0d,%0d), got %0d %0d (%0d,%0d)",
                   want.status, want.length, want.row, want.col, st, len, r, c);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we;
  logic                 cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_action;
  logic [ROW_W-1:0]     in_cell_row;
  logic [COL_W-1:0]     in_cell_col;
  logic                 in_cell_blocked;
  logic [ADDR_W-1:0]    in_entry_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    out_status;
  logic [DEPTH_W-1:0]   out_path_length;
  logic [ROW_W-1:0]     out_entry_row;
  logic [COL_W-1:0]     out_entry_col;

  maze_path_tracker sb;
  int send_run = 0;
  int sink_run = 0;
  int items_sent = 0;

  grid_maze_dfs_path_search_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .in_cell_blocked (in_cell_blocked),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_path_length (out_path_length),
    .out_entry_row   (out_entry_row),
    .out_entry_col   (out_entry_col)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly random waits, now and then a run of back-to-back transfers
  function automatic int pick_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [DIM_W-1:0] dim_code(input int n, input int lim);
    if (n == 1) return DIM_W'($urandom_range(0, 1));
    if (n == lim) return DIM_W'($urandom_range(lim, 31));
    return DIM_W'(n);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_index();
    int n;
    n = sb.trail_len;
    case ($urandom_range(0, 5))
      0: return ADDR_W'($urandom_range(0, 255));
      1: return ADDR_W'(n);
      default: return (n > 0) ? ADDR_W'($urandom_range(0, n - 1)) : ADDR_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic b,
                           input logic [ADDR_W-1:0] idx);
    int gap;
    gap = pick_gap(send_run);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_cell_row     <= r;
    in_cell_col     <= c;
    in_cell_blocked <= b;
    in_entry_index  <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(act, r, c, b, idx);
    items_sent++;
  endtask

  task automatic put_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                          input logic b);
    send_item(ACT_WRITE, r, c, b, ADDR_W'($urandom_range(0, 255)));
  endtask

  task automatic run_search();
    send_item(ACT_SEARCH, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 255)));
  endtask

  task automatic read_entry(input logic [ADDR_W-1:0] idx);
    send_item(ACT_READ, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)), idx);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] rv, input logic [DIM_W-1:0] cv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= rv;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_data  <= cv;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_dims(rv, cv);
  endtask

  task automatic random_phase(input int rows, input int cols);
    int rounds, nw, nr;
    set_grid(dim_code(rows, MAX_ROWS), dim_code(cols, MAX_COLS));
    rounds = $urandom_range(1, 4);
    repeat (rounds) begin
      nw = $urandom_range(0, 6);
      repeat (nw) begin
        case ($urandom_range(0, 9))
          0: put_cell(ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
          1: send_item(ACT_NONE, ROW_W'($urandom_range(0, 15)), COL_W'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 255)));
          2: read_entry(pick_index());
          default: put_cell(ROW_W'($urandom_range(0, rows - 1)),
                            COL_W'($urandom_range(0, cols - 1)),
                            $urandom_range(0, 2) == 0);
        endcase
      end
      run_search();
      nr = $urandom_range(0, 5);
      repeat (nr) read_entry(pick_index());
    end
  endtask

  // full grid with walls on odd rows 1 to 13, one random gap each: long path, no deep backtracking
  task automatic carve_serpentine();
    int k, w, c, gap;
    set_grid(dim_code(MAX_ROWS, MAX_ROWS), dim_code(MAX_COLS, MAX_COLS));
    for (k = 0; k < CELL_CNT; k++)
      if (sb.blocked[k]) put_cell(ROW_W'(k / MAX_COLS), COL_W'(k % MAX_COLS), 1'b0);
    for (w = 1; w < MAX_ROWS - 2; w += 2) begin
      gap = $urandom_range(0, MAX_COLS - 1);
      for (c = 0; c < MAX_COLS; c++)
        if (c != gap) put_cell(ROW_W'(w), COL_W'(c), 1'b1);
    end
    run_search();
    repeat (12) read_entry(pick_index());
  endtask

  initial begin : result_sink
    int hold, taken;
    taken = 0;
    out_stall <= 1'b1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      hold = pick_gap(sink_run);
      // long hold-offs back up the engine so that it stalls its input
      if (taken == 40 || taken == 500 || taken == 1000) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_answer(out_status, out_path_length, out_entry_row, out_entry_col);
      taken++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("grid_maze_dfs_path_search_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int phase, rows, cols;
    sb = new();
    cfg_we          <= 1'b0;
    cfg_index       <= REG_ROWS;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_action       <= ACT_WRITE;
    in_cell_row     <= '0;
    in_cell_col     <= '0;
    in_cell_blocked <= 1'b0;
    in_entry_index  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // open 16x16 grid straight after reset
    run_search();
    read_entry(8'd0);
    read_entry(8'd30);
    read_entry(8'd31);
    read_entry(8'd255);
    send_item(ACT_NONE, 4'hf, 4'hf, 1'b1, 8'hff);
    // stored path survives cell writes
    put_cell(4'd15, 4'd15, 1'b1);
    read_entry(8'd30);

    // one-cell grid with the start blocked
    settle();
    set_grid(5'd0, 5'd1);
    put_cell(4'd0, 4'd0, 1'b1);
    run_search();
    read_entry(8'd0);
    read_entry(8'd1);

    // blocked goal, then reopened; start stays blocked
    settle();
    set_grid(5'd3, 5'd3);
    put_cell(4'd2, 4'd2, 1'b1);
    run_search();
    read_entry(8'd0);
    put_cell(4'd2, 4'd2, 1'b0);
    run_search();
    read_entry(8'd4);

    settle();
    set_grid(5'd31, 5'd1);
    run_search();
    read_entry(8'd15);

    settle();
    set_grid(5'd1, 5'd31);
    run_search();
    read_entry(8'd15);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      if (phase % 25 == 12) begin
        carve_serpentine();
      end else begin
        // small areas keep the exhaustive no-path searches short
        case ($urandom_range(0, 5))
          3: begin
            rows = $urandom_range(1, 2);
            cols = (rows == 1) ? $urandom_range(1, MAX_COLS) : $urandom_range(1, 8);
          end
          4: begin
            cols = $urandom_range(1, 2);
            rows = (cols == 1) ? $urandom_range(1, MAX_ROWS) : $urandom_range(1, 8);
          end
          5: begin
            if ($urandom_range(0, 1)) begin
              rows = 1;
              cols = MAX_COLS;
            end else begin
              rows = MAX_ROWS;
              cols = 1;
            end
          end
          default: begin
            rows = $urandom_range(1, 4);
            cols = $urandom_range(1, (rows <= 2) ? 4 : 6 - rows);
          end
        endcase
        random_phase(rows, cols);
      end
      phase++;
    end

    settle();
    if (sb.bad_count == 0 && sb.awaited.size() == 0) begin
      $display("grid_maze_dfs_path_search_core: match");
    end else begin
      $display("grid_maze_dfs_path_search_core: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: grid_maze_dfs_path_search_core.f
hw/rtl/gmd_pkg.sv
hw/rtl/gmd_ram.sv
hw/rtl/gmd_useq.sv
hw/rtl/gmd_dpath.sv
hw/rtl/grid_maze_dfs_path_search_core.sv
verif/tb.sv
